// File: sv/rolling_hash_substring_matcher_defines.svh
// Assertion macros for the rolling hash substring matcher.
// Included by the checker; depends on nothing else.
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define RHSM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define RHSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rhsm_pkg.sv
// Shared types, constants and helper functions of the rolling hash substring matcher.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rhsm_pkg;

    localparam int LEN_W  = 5;
    localparam int HASH_W = 26;
    localparam int POS_W  = 32;
    localparam int BYTE_W = 8;
    localparam int PAT_W  = 128;
    localparam int WIN_IDX_W = 4;

    // ceil(2^27 / 3): x * DIV3_MUL >> 27 equals x / 3 for every 26-bit x
    localparam logic [HASH_W-1:0] DIV3_MUL = 26'd44739243;
    localparam int DIV3_SHIFT = 27;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_HASH  = 2'd0,
        KIND_POS   = 2'd1,
        KIND_SHORT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_LEN  = 2'd0,
        REG_LOW  = 2'd1,
        REG_HIGH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        logic [BYTE_W-1:0] text_byte;
    } t_in;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] value;
        logic             last;
    } t_out;

    // Per-cycle command broadcast along the window cells
    typedef struct packed {
        logic                 clear;
        logic                 fill;
        logic                 shift;
        logic [WIN_IDX_W-1:0] idx;
        logic [WIN_IDX_W-1:0] len_m1;
        logic [BYTE_W-1:0]    byte_in;
    } t_cell_ctl;

    function automatic logic [HASH_W-1:0] pow3(input logic [WIN_IDX_W-1:0] i);
        logic [HASH_W-1:0] p;
        case (i)
            4'd0:    p = 26'd1;
            4'd1:    p = 26'd3;
            4'd2:    p = 26'd9;
            4'd3:    p = 26'd27;
            4'd4:    p = 26'd81;
            4'd5:    p = 26'd243;
            4'd6:    p = 26'd729;
            4'd7:    p = 26'd2187;
            4'd8:    p = 26'd6561;
            4'd9:    p = 26'd19683;
            4'd10:   p = 26'd59049;
            4'd11:   p = 26'd177147;
            4'd12:   p = 26'd531441;
            4'd13:   p = 26'd1594323;
            4'd14:   p = 26'd4782969;
            default: p = 26'd14348907;
        endcase
        return p;
    endfunction

    // b mod 3 through the reciprocal 171 / 512
    function automatic logic [1:0] mod3(input logic [BYTE_W-1:0] b);
        logic [16:0] prod;
        logic [7:0]  q;
        logic [9:0]  q3;
        logic [9:0]  r;
        prod = 17'(b) * 17'd171;
        q    = prod[16:9];
        q3   = 10'(q) * 10'd3;
        r    = 10'(b) - q3;
        return r[1:0];
    endfunction

    // (b mod 3) * 3^i
    function automatic logic [HASH_W-1:0] hash_term(input logic [BYTE_W-1:0] b,
                                                    input logic [WIN_IDX_W-1:0] i);
        logic [1:0]        m;
        logic [HASH_W-1:0] p;
        logic [HASH_W-1:0] t;
        m = mod3(b);
        p = pow3(i);
        case (m)
            2'd1:    t = p;
            2'd2:    t = p << 1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// File: sv/rhsm_cell.sv
// One window cell: holds one text byte, fills, shifts toward cell 0, compares to its pattern byte.
// Depends on rhsm_pkg.
`default_nettype none
module rhsm_cell
    import rhsm_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [BYTE_W-1:0] i_next,
    input  wire logic [BYTE_W-1:0] i_pat,
    output logic      [BYTE_W-1:0] o_byte,
    output logic                   o_eq
);

    localparam logic [WIN_IDX_W-1:0] MY_IDX = WIN_IDX_W'(CELL_IDX);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.fill && (i_ctl.idx == MY_IDX)) begin
            n_byte = i_ctl.byte_in;
        end else if (i_ctl.shift) begin
            // cells past the window end hold their byte
            if (MY_IDX < i_ctl.len_m1) begin
                n_byte = i_next;
            end else if (MY_IDX == i_ctl.len_m1) begin
                n_byte = i_ctl.byte_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_pat);

endmodule
`default_nettype wire

// File: sv/rhsm_phash.sv
// Pattern hash unit: sums (byte mod 3) * 3^i over the pattern, one byte per cycle.
// Restarts on every configuration write. Depends on rhsm_pkg.
`default_nettype none
module rhsm_phash
    import rhsm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire logic [PAT_W-1:0]  i_pattern,
    output logic      [HASH_W-1:0] o_hash,
    output logic                   o_busy
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PATTERN - 1);

    logic [IDX_W-1:0]  r_cnt;
    logic [HASH_W-1:0] r_acc;
    logic              r_busy;
    logic [BYTE_W-1:0] w_pbyte;

    assign w_pbyte = i_pattern[32'(r_cnt) * BYTE_W +: BYTE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_acc  <= '0;
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= '0;
            r_acc  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (LEN_W'(r_cnt) < i_len) begin
                r_acc <= r_acc + hash_term(w_pbyte, WIN_IDX_W'(r_cnt));
            end
            if (r_cnt == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_hash = r_acc;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

// File: sv/rolling_hash_substring_matcher.sv
// A byte that fills a full window reaches its hash check in the cycle after it is taken; one
// that rolls it passes the divide-by-3 roll state first. Throughput: one filling byte per cycle
// while o_in_ready is high; a full-window byte blocks input until its roll, check and results
// are done. Each configuration write restarts the pattern hash unit, which holds o_in_ready low
// while it runs. Synchronous active-low reset clears window, hash and count; length is 1.
`default_nettype none
module rolling_hash_substring_matcher
    import rhsm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROLL  = 5'b00010,
        S_CHECK = 5'b00100,
        S_POS   = 5'b01000,
        S_SHORT = 5'b10000
    } t_state;

    // configuration
    logic [LEN_W-1:0] r_pattern_len;
    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [PAT_W-1:0] w_pattern;
    logic [LEN_W-1:0] w_len;

    // control and datapath state
    t_state            r_state;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_term;
    logic [POS_W-1:0]  r_bytes_seen;
    logic [POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_need_hash;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_accept;
    logic              w_filling;
    logic              w_load_ok;
    logic              w_out_load;
    logic              w_match;
    logic              w_pos_last;
    logic [HASH_W-1:0] w_sub;
    logic [HASH_W-1:0] w_quot;
    logic [2*HASH_W+1:0] w_prod;
    logic [HASH_W-1:0] w_phash;
    logic              w_ph_busy;
    t_cell_ctl         w_ctl;
    logic [BYTE_W-1:0] w_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;

    assign w_pattern = {r_pattern_high, r_pattern_low};
    assign w_len = (r_pattern_len == '0) ? LEN_W'(1) :
                   (r_pattern_len > MAX_LEN) ? MAX_LEN : r_pattern_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len  <= LEN_W'(1);
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LEN:  r_pattern_len  <= i_cfg_data[LEN_W-1:0];
                REG_LOW:  r_pattern_low  <= i_cfg_data;
                REG_HIGH: r_pattern_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rhsm_phash #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_phash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_len    (w_len),
        .i_pattern(w_pattern),
        .o_hash   (w_phash),
        .o_busy   (w_ph_busy)
    );

    assign o_in_ready = (r_state == S_IDLE) && !w_ph_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_filling  = (r_bytes_seen < POS_W'(w_len));

    // window cells
    always_comb begin
        w_ctl.clear   = w_accept && (i_in_data.op == OP_END);
        w_ctl.fill    = w_accept && (i_in_data.op == OP_BYTE) && w_filling;
        w_ctl.shift   = w_accept && (i_in_data.op == OP_BYTE) && !w_filling;
        w_ctl.idx     = r_bytes_seen[WIN_IDX_W-1:0];
        w_ctl.len_m1  = WIN_IDX_W'(w_len - LEN_W'(1));
        w_ctl.byte_in = i_in_data.text_byte;
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic [BYTE_W-1:0] w_next;
        if (g == MAX_PATTERN - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_bytes[g+1];
        end
        rhsm_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_next (w_next),
            .i_pat  (w_pattern[g*BYTE_W +: BYTE_W]),
            .o_byte (w_bytes[g]),
            .o_eq   (w_eq[g])
        );
    end

    // drop the oldest term, then divide by 3 in the roll cycle
    assign w_sub  = r_hash - HASH_W'(mod3(w_bytes[0]));
    assign w_prod = (2*HASH_W+2)'(r_hash) * (2*HASH_W+2)'(DIV3_MUL);
    assign w_quot = w_prod[DIV3_SHIFT +: HASH_W];

    assign w_load_ok  = !r_out_valid || i_out_ready;
    assign w_match    = (r_hash == w_phash);
    assign w_pos_last = !w_eq[r_cmp_idx] || (LEN_W'(r_cmp_idx) == (w_len - LEN_W'(1)));
    assign w_out_load = w_load_ok && (((r_state == S_CHECK) && r_need_hash) ||
                                      (r_state == S_POS) || (r_state == S_SHORT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hash       <= '0;
            r_bytes_seen <= '0;
            r_need_hash  <= 1'b0;
            r_cmp_idx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_data.op == OP_END) begin
                            r_hash       <= '0;
                            r_bytes_seen <= '0;
                            r_state      <= w_filling ? S_SHORT : S_IDLE;
                        end else if (w_filling) begin
                            r_hash <= r_hash + hash_term(i_in_data.text_byte,
                                                         r_bytes_seen[WIN_IDX_W-1:0]);
                            r_bytes_seen <= r_bytes_seen + 1'b1;
                            if (r_bytes_seen == POS_W'(w_len - LEN_W'(1))) begin
                                r_need_hash <= 1'b1;
                                r_state     <= S_CHECK;
                            end
                        end else begin
                            r_hash <= w_sub;
                            r_term <= hash_term(i_in_data.text_byte,
                                                WIN_IDX_W'(w_len - LEN_W'(1)));
                            if (r_bytes_seen != '1) begin
                                r_bytes_seen <= r_bytes_seen + 1'b1;
                            end
                            r_state <= S_ROLL;
                        end
                    end
                end
                S_ROLL: begin
                    r_hash  <= w_quot + r_term;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_pos     <= r_bytes_seen - POS_W'(w_len) + 1'b1;
                    r_cmp_idx <= '0;
                    if (r_need_hash) begin
                        if (w_load_ok) begin
                            r_out.kind  <= KIND_HASH;
                            r_out.value <= POS_W'(w_phash);
                            r_out.last  <= !w_match;
                            r_need_hash <= 1'b0;
                            r_state     <= w_match ? S_POS : S_IDLE;
                        end
                    end else begin
                        r_state <= w_match ? S_POS : S_IDLE;
                    end
                end
                S_POS: begin
                    if (w_load_ok) begin
                        r_out.kind  <= KIND_POS;
                        r_out.value <= r_pos;
                        r_out.last  <= w_pos_last;
                        r_pos       <= r_pos + 1'b1;
                        r_cmp_idx   <= r_cmp_idx + 1'b1;
                        if (w_pos_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHORT: begin
                    if (w_load_ok) begin
                        r_out.kind  <= KIND_SHORT;
                        r_out.value <= '0;
                        r_out.last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: sv/rhsm_checker.sv
// Port-level checker for the rolling hash substring matcher, bound to the top level.
// Depends on rhsm_pkg and the assertion macro header.
`default_nettype none
`include "rolling_hash_substring_matcher_defines.svh"
module rhsm_checker
    import rhsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_ready,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out        o_out_data,
    input  wire logic        i_cfg_we
);

    // a stalled result holds
    `RHSM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")
    // a short-text result is always zero and final
    `RHSM_ASSERT(a_short_form, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_SHORT) |-> (o_out_data.value == 32'd0) && o_out_data.last, "malformed short-text result")
    // pattern hash never exceeds 3^16 - 1
    `RHSM_ASSERT(a_hash_range, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == KIND_HASH) |-> (o_out_data.value < 32'd43046721), "pattern hash out of range")
    // a configuration write starts the pattern hash and holds off input
    `RHSM_ASSERT_ALWAYS(a_cfg_block, i_clk, i_rst_n && i_cfg_we |=> !o_in_ready, "input taken right after a configuration write")

endmodule

bind rolling_hash_substring_matcher rhsm_checker u_rhsm_checker (.*);
`default_nettype wire

// File: dv/rolling_hash_substring_matcher_tb.sv
// Self-checking testbench for the rolling hash substring matcher: directed and random text
// streams under random sender bursts and receiver stalls, checked against an in-bench predictor.
// Depends on rhsm_pkg and the rolling_hash_substring_matcher top level.
`default_nettype none
module rolling_hash_substring_matcher_tb;
    import rhsm_pkg::*;

    localparam int          MAX_PAT      = 16;
    localparam logic [31:0] HASH_MASK    = (32'd1 << HASH_W) - 32'd1;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          TOTAL_ITEMS  = 200;
    localparam int          PRINT_LIMIT  = 40;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data  = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we   = 1'b0;
    t_cfg_idx    cfg_idx  = REG_LEN;
    logic [63:0] cfg_data = '0;
    wire logic   in_ready;
    wire logic   out_valid;
    t_out        out_data;

    rolling_hash_substring_matcher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor copy of registers and window state
    logic [4:0]   reg_len     = 5'd1;
    logic [127:0] reg_pattern = '0;
    logic [7:0]   win_bytes [MAX_PAT];
    logic [31:0]  win_hash    = '0;
    logic [31:0]  win_count   = '0;

    t_in  text_items_q [$];
    t_out match_results_q [$];
    int   mismatches   = 0;
    int   queued_items = 0;
    logic pressure_on  = 1'b0;

    initial begin
        for (int i = 0; i < MAX_PAT; i++) win_bytes[i] = '0;
    end

    function automatic int unsigned active_len();
        int unsigned l;
        l = reg_len;
        if (l == 0) l = 1;
        if (l > MAX_PAT) l = MAX_PAT;
        return l;
    endfunction

    function automatic logic [7:0] pattern_byte(int unsigned i);
        return reg_pattern[i*8 +: 8];
    endfunction

    function automatic logic [31:0] trit_weight(int unsigned i);
        logic [31:0] w;
        int unsigned j;
        w = 32'd1;
        for (j = 0; j < i; j++) w = w * 32'd3;
        return w;
    endfunction

    function automatic logic [31:0] pattern_sum(int unsigned l);
        logic [31:0] h;
        int unsigned i;
        h = '0;
        for (i = 0; i < l; i++) h = h + (32'(pattern_byte(i)) % 32'd3) * trit_weight(i);
        return h & HASH_MASK;
    endfunction

    function automatic void push_result(t_kind kind, logic [31:0] value);
        t_out r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        match_results_q.push_back(r);
    endfunction

    function automatic void compare_window(int unsigned l);
        logic [31:0] start;
        int unsigned i;
        if (win_hash != pattern_sum(l)) return;
        start = win_count - 32'(l) + 32'd1;
        for (i = 0; i < l; i++) begin
            push_result(KIND_POS, start + 32'(i));
            if (win_bytes[i] != pattern_byte(i)) break;
        end
    endfunction

    function automatic void predict_matches(t_in item);
        int unsigned l;
        int unsigned i;
        int unsigned n0;
        logic [31:0] h;
        logic [7:0]  b;
        t_out        tail;
        l  = active_len();
        n0 = match_results_q.size();
        b  = item.text_byte;
        if (item.op == OP_END) begin
            if (win_count < l) push_result(KIND_SHORT, '0);
            for (i = 0; i < MAX_PAT; i++) win_bytes[i] = '0;
            win_hash  = '0;
            win_count = '0;
        end else if (win_count < l) begin
            win_bytes[win_count[3:0]] = b;
            win_hash = (win_hash + (32'(b) % 32'd3) * trit_weight(win_count[3:0])) & HASH_MASK;
            win_count = win_count + 32'd1;
            if (win_count == l) begin
                push_result(KIND_HASH, pattern_sum(l));
                compare_window(l);
            end
        end else begin
            // roll out the oldest byte, then add the new one at the top weight
            h = ((win_hash - (32'(win_bytes[0]) % 32'd3)) & HASH_MASK) / 32'd3;
            win_hash = (h + (32'(b) % 32'd3) * trit_weight(l - 1)) & HASH_MASK;
            for (i = 0; i + 1 < l; i++) win_bytes[i] = win_bytes[i+1];
            win_bytes[l-1] = b;
            // position saturation needs 2^32 bytes and stays out of reach here
            if (win_count != '1) win_count = win_count + 32'd1;
            compare_window(l);
        end
        if (match_results_q.size() > n0) begin
            tail = match_results_q.pop_back();
            tail.last = 1'b1;
            match_results_q.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT) $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Driver: bursts of transfers with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    logic        nxt_valid;
    t_in         nxt_data;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            if (in_valid && in_ready) begin
                predict_matches(in_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (text_items_q.size() != 0) begin
                    nxt_data  = text_items_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            in_valid <= nxt_valid;
            in_data  <= nxt_data;
        end
    end

    // Receiver: stall pattern that changes mode, plus one long hold-off under pressure
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    logic [1:0]  rx_mode   = '0;
    logic [7:0]  rx_tick   = '0;
    logic        prev_pressure = 1'b0;
    logic        nxt_ready;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            prev_pressure <= pressure_on;
            rx_tick <= rx_tick + 8'd1;
            if (pressure_on && !prev_pressure) begin
                hold_left <= 400;
                nxt_ready = 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                nxt_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   <= 2'($urandom_range(0, 3));
                    mode_left <= $urandom_range(8, 80);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    2'd0:    nxt_ready = 1'b1;
                    2'd1:    nxt_ready = 1'($urandom_range(0, 1));
                    2'd2:    nxt_ready = ($urandom_range(0, 3) == 0);
                    default: nxt_ready = (rx_tick[2:0] < 3'd5);
                endcase
            end
            out_ready <= nxt_ready;
        end
    end

    // Monitor: check every output transfer against the oldest expectation
    int unsigned result_idx = 0;
    t_out        want;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (match_results_q.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: kind %0d value %0d last %0d",
                    result_idx, out_data.kind, out_data.value, out_data.last));
            end else begin
                want = match_results_q.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch($sformatf("result %0d kind %0d, want %0d",
                        result_idx, out_data.kind, want.kind));
                if (out_data.value !== want.value)
                    report_mismatch($sformatf("result %0d value %0d, want %0d",
                        result_idx, out_data.value, want.value));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("result %0d last %0d, want %0d",
                        result_idx, out_data.last, want.last));
            end
            result_idx++;
        end
    end

    // Watchdog: end the run when work is outstanding but nothing transfers
    int unsigned stall_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (text_items_q.size() == 0 && !in_valid && match_results_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_item(t_op op, logic [7:0] b);
        t_in it;
        it.op        = op;
        it.text_byte = b;
        text_items_q.push_back(it);
        queued_items++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_LEN: reg_len = data[4:0];
            REG_LOW: reg_pattern[63:0] = data;
            default: reg_pattern[127:64] = data;
        endcase
    endtask

    task automatic set_pattern(logic [4:0] len, logic [127:0] pat);
        // upper bits of the length write are don't-care; drive them random
        write_reg(REG_LEN, {32'($urandom), 27'($urandom), len});
        write_reg(REG_LOW, pat[63:0]);
        write_reg(REG_HIGH, pat[127:64]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every item is sent and every result is back, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        while (text_items_q.size() != 0 || in_valid || match_results_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly pattern copies with rare mutations, mixed with loose bytes and stray ends
    task automatic queue_text(int unsigned n_items, bit with_end);
        int unsigned l;
        int unsigned k;
        int unsigned j;
        logic [7:0]  b;
        l = active_len();
        k = 0;
        while (k < n_items) begin
            if ($urandom_range(0, 9) < 6) begin
                for (j = 0; j < l && k < n_items; j++) begin
                    b = pattern_byte(j);
                    case ($urandom_range(0, 15))
                        0:       b = b ^ (8'd1 << $urandom_range(0, 7));
                        1:       b = b + 8'd3;
                        default: ;
                    endcase
                    queue_item(OP_BYTE, b);
                    k++;
                end
            end else begin
                b = ($urandom_range(0, 2) == 0) ? pattern_byte($urandom_range(0, l - 1))
                                                : 8'($urandom);
                queue_item(OP_BYTE, b);
                k++;
            end
            if ($urandom_range(0, 40) == 0) begin
                queue_item(OP_END, 8'($urandom));
                k++;
            end
        end
        if (with_end) queue_item(OP_END, 8'($urandom));
    endtask

    initial begin
        logic [4:0]   len;
        logic [127:0] pat;
        logic         pressure_done;
        pressure_done = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: zero bytes match, a collision byte, end after fill, end on empty
        @(negedge clk);
        queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'hFF);
        queue_item(OP_END, 8'hFF);
        queue_item(OP_END, 8'h00);
        wait_drained();

        // Length zero acts as one; second byte collides in hash only
        set_pattern(5'd0, 128'h41);
        @(negedge clk);
        queue_item(OP_BYTE, 8'h41);
        queue_item(OP_BYTE, 8'h44);
        queue_item(OP_END, 8'h5A);
        wait_drained();

        // Oversize length clamps to the maximum; an exact copy gives the most results
        set_pattern(5'd31, 128'hFF00_807F_01FE_AA55_33CC_0FF0_12ED_6996);
        @(negedge clk);
        for (int i = 0; i < MAX_PAT; i++) queue_item(OP_BYTE, pattern_byte(i));
        wait_drained();

        // Shrink the length mid-text, without an end in between
        set_pattern(5'd2, reg_pattern);
        @(negedge clk);
        queue_item(OP_BYTE, 8'h12);
        queue_item(OP_END, 8'h00);
        wait_drained();

        while (queued_items < TOTAL_ITEMS) begin
            if (!pressure_done && queued_items > 90) begin
                // one repeated byte: many windows match and the output backs up
                pat = {MAX_PAT{8'($urandom)}};
                set_pattern(5'd6, pat);
                @(negedge clk);
                pressure_on = 1'b1;
                queue_text(40, 1'b1);
                wait_drained();
                pressure_on   = 1'b0;
                pressure_done = 1'b1;
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       len = 5'd0;
                        1:       len = 5'd16;
                        2:       len = 5'($urandom_range(17, 31));
                        3:       len = 5'($urandom_range(7, 15));
                        default: len = 5'($urandom_range(1, 6));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       pat = '0;
                        1:       pat = '1;
                        default: pat = {$urandom, $urandom, $urandom, $urandom};
                    endcase
                    set_pattern(len, pat);
                end
                @(negedge clk);
                queue_text($urandom_range(12, 30), $urandom_range(0, 3) != 0);
                wait_drained();
            end
        end

        if (match_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", match_results_q.size()));
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/rhsm_pkg.sv
sv/rhsm_cell.sv
sv/rhsm_phash.sv
sv/rolling_hash_substring_matcher.sv
sv/rhsm_checker.sv
dv/rolling_hash_substring_matcher_tb.sv
